@@ sv/i2cra_pkg.sv @@
// shared types and codes for the i2c register access master
// no dependencies; used by i2cra_engine and i2c_master_register_access_top
package i2cra_pkg;

   localparam int TICK_COUNT_WIDTH_DEFAULT = 12;
   localparam int ADDR_WIDTH   = 7;
   localparam int HALF_WIDTH   = 12;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 12;

   localparam logic [ADDR_WIDTH-1:0] DEVICE_ADDRESS_RESET = 7'd76;
   localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_RESET    = 12'd8;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DEVICE_ADDRESS = 2'd0,
      CSR_HALF_PERIOD    = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic       success;
      logic [7:0] read_data;
   } rsp_type;

endpackage

@@ sv/i2cra_engine.sv @@
// bus sequencer: start, byte shifting, acknowledge, repeated start and stop
// depends on i2cra_pkg; advances one tick on each accepted word
module i2cra_engine #(
   parameter int TICK_COUNT_WIDTH = i2cra_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  i2cra_pkg::req_type                  req,
   input  logic [i2cra_pkg::ADDR_WIDTH-1:0]    device_address,
   input  logic [i2cra_pkg::HALF_WIDTH-1:0]    half_period_ticks,
   output i2cra_pkg::rsp_type                  rsp
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_FREE, PH_ST_FALL, PH_ST_HOLD,
      PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_HIGH,
      PH_RS_LOW, PH_RX_LOW, PH_RX_HIGH, PH_NACK_LOW,
      PH_NACK_HIGH, PH_SP_LOW, PH_SP_RISE, PH_SP_FREE
   } phase_type;

   typedef enum logic [1:0] {
      STAGE_ADDR_W, STAGE_REG, STAGE_DATA, STAGE_ADDR_R
   } stage_type;

   localparam int TW = TICK_COUNT_WIDTH;

   phase_type             phase_ff, phase_in;
   stage_type             stage_ff, stage_in;
   logic [3:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in;
   logic [TW-1:0]         tick_ff, tick_in;
   logic                  is_read_ff, is_read_in;
   logic [7:0]            reg_ff, reg_in;
   logic [7:0]            data_ff, data_in;
   logic                  ack_ff, ack_in;
   logic [7:0]            rx_ff, rx_in;

   logic [i2cra_pkg::HALF_WIDTH+TW-1:0] half_wide;
   logic [TW-1:0]         half_trunc;
   logic [TW:0]           half_eff;
   logic [TW:0]           tick_next;
   logic [3:0]            bit_next;
   logic                  done;
   logic                  op_start;

   assign half_wide  = {{TW{1'b0}}, half_period_ticks};
   assign half_trunc = half_wide[TW-1:0];
   assign half_eff   = (half_trunc == '0) ? (TW+1)'(1) : {1'b0, half_trunc};
   assign tick_next  = {1'b0, tick_ff} + (TW+1)'(1);
   assign bit_next   = bit_ff + 4'd1;
   assign op_start   = (req.operation == i2cra_pkg::OP_WRITE) ||
                       (req.operation == i2cra_pkg::OP_READ);

   always_comb begin
      phase_in   = phase_ff;
      stage_in   = stage_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      tick_in    = tick_ff;
      is_read_in = is_read_ff;
      reg_in     = reg_ff;
      data_in    = data_ff;
      ack_in     = ack_ff;
      rx_in      = rx_ff;
      done       = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (op_start) begin
            is_read_in = (req.operation == i2cra_pkg::OP_READ);
            reg_in     = req.register_address;
            data_in    = req.write_data;
            ack_in     = 1'b1;
            rx_in      = '0;
            bit_in     = '0;
            stage_in   = STAGE_ADDR_W;
            tick_in    = '0;
            phase_in   = PH_ST_FREE;
         end
      end else if (tick_next >= half_eff) begin
         tick_in = '0;
         unique case (phase_ff)
            PH_IDLE:    phase_in = PH_IDLE;
            PH_ST_FREE: phase_in = PH_ST_FALL;
            PH_ST_FALL: phase_in = PH_ST_HOLD;
            PH_ST_HOLD: begin
               shift_in = {device_address, stage_ff == STAGE_ADDR_R};
               bit_in   = '0;
               phase_in = PH_TX_LOW;
            end
            PH_TX_LOW:  phase_in = PH_TX_HIGH;
            PH_TX_HIGH: begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_next;
               phase_in = bit_next[3] ? PH_ACK_LOW : PH_TX_LOW;
            end
            PH_ACK_LOW: phase_in = PH_ACK_HIGH;
            PH_ACK_HIGH: begin
               if (req.sda_in) begin
                  ack_in   = 1'b0;
                  phase_in = PH_SP_LOW;
               end else begin
                  unique case (stage_ff)
                     STAGE_ADDR_W: begin
                        stage_in = STAGE_REG;
                        shift_in = reg_ff;
                        bit_in   = '0;
                        phase_in = PH_TX_LOW;
                     end
                     STAGE_REG: begin
                        if (is_read_ff) begin
                           stage_in = STAGE_ADDR_R;
                           phase_in = PH_RS_LOW;
                        end else begin
                           stage_in = STAGE_DATA;
                           shift_in = data_ff;
                           bit_in   = '0;
                           phase_in = PH_TX_LOW;
                        end
                     end
                     STAGE_DATA: phase_in = PH_SP_LOW;
                     STAGE_ADDR_R: begin
                        bit_in   = '0;
                        rx_in    = '0;
                        phase_in = PH_RX_LOW;
                     end
                  endcase
               end
            end
            PH_RS_LOW:  phase_in = PH_ST_FREE;
            PH_RX_LOW:  phase_in = PH_RX_HIGH;
            PH_RX_HIGH: begin
               rx_in    = {rx_ff[6:0], req.sda_in};
               bit_in   = bit_next;
               phase_in = bit_next[3] ? PH_NACK_LOW : PH_RX_LOW;
            end
            PH_NACK_LOW:  phase_in = PH_NACK_HIGH;
            PH_NACK_HIGH: phase_in = PH_SP_LOW;
            PH_SP_LOW:    phase_in = PH_SP_RISE;
            PH_SP_RISE:   phase_in = PH_SP_FREE;
            PH_SP_FREE: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         endcase
      end else begin
         tick_in = tick_next[TW-1:0];
      end
   end

   always_comb begin
      unique case (phase_in) inside
         PH_ST_FALL, PH_SP_RISE: begin
            rsp.scl_release = 1'b1;
            rsp.sda_release = 1'b0;
         end
         PH_ST_HOLD, PH_SP_LOW: begin
            rsp.scl_release = 1'b0;
            rsp.sda_release = 1'b0;
         end
         PH_TX_LOW: begin
            rsp.scl_release = 1'b0;
            rsp.sda_release = shift_in[7];
         end
         PH_TX_HIGH: begin
            rsp.scl_release = 1'b1;
            rsp.sda_release = shift_in[7];
         end
         PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW, PH_NACK_LOW: begin
            rsp.scl_release = 1'b0;
            rsp.sda_release = 1'b1;
         end
         default: begin
            rsp.scl_release = 1'b1;
            rsp.sda_release = 1'b1;
         end
      endcase
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done;
      rsp.success   = done & ack_in;
      rsp.read_data = (done && ack_in && is_read_in) ? rx_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         stage_ff   <= STAGE_ADDR_W;
         bit_ff     <= '0;
         shift_ff   <= '0;
         tick_ff    <= '0;
         is_read_ff <= 1'b0;
         reg_ff     <= '0;
         data_ff    <= '0;
         ack_ff     <= 1'b0;
         rx_ff      <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         stage_ff   <= stage_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         tick_ff    <= tick_in;
         is_read_ff <= is_read_in;
         reg_ff     <= reg_in;
         data_ff    <= data_in;
         ack_ff     <= ack_in;
         rx_ff      <= rx_in;
      end
   end

endmodule

@@ sv/i2c_master_register_access_top.sv @@
// I2C master for single-byte register reads and writes. Each request word is one
// bus timing tick carrying an optional operation and the sampled SDA level; each
// tick returns one response word with the SCL/SDA release levels, busy, done,
// success and read data. A word is taken every clock cycle unless stalled; the
// sequencer state advances on acceptance and the response sits in a single
// output register, so the request side stays ready whenever that register is
// empty or being drained. The user writes configuration (device address, ticks
// per half bit phase) via the csr port while the bus is idle (unchecked).
// depends on i2cra_pkg and i2cra_engine
module i2c_master_register_access_top #(
   parameter int TICK_COUNT_WIDTH = i2cra_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  i2cra_pkg::req_type                      req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output i2cra_pkg::rsp_type                      rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [i2cra_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [i2cra_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   logic [i2cra_pkg::ADDR_WIDTH-1:0] dev_addr_ff;
   logic [i2cra_pkg::HALF_WIDTH-1:0] half_ff;
   logic                             rsp_valid_ff;
   i2cra_pkg::rsp_type               rsp_ff;
   i2cra_pkg::rsp_type               rsp_in;
   logic                             step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   i2cra_engine #(
      .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .req               (req_data),
      .device_address    (dev_addr_ff),
      .half_period_ticks (half_ff),
      .rsp               (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= i2cra_pkg::DEVICE_ADDRESS_RESET;
         half_ff     <= i2cra_pkg::HALF_PERIOD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            i2cra_pkg::CSR_DEVICE_ADDRESS: dev_addr_ff <= csr_wdata[i2cra_pkg::ADDR_WIDTH-1:0];
            i2cra_pkg::CSR_HALF_PERIOD:    half_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
